>>> sv/ont_pkg.sv
// ----------------------------------------------------------------------------
// ont_pkg: shared types and helpers for the ordered name table
// Command and status codes, sequencer states and name canonicalization.
// ----------------------------------------------------------------------------
`default_nettype none

package ont_pkg;

    localparam int ONT_DEPTH  = 16;
    localparam int NAME_CHARS = 14;
    localparam int NAME_W     = NAME_CHARS * 8;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_DELETE = 2'd3
    } ont_cmd_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_POS  = 2'd1,
        STAT_MISS = 2'd2,
        STAT_FULL = 2'd3
    } ont_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_PLACE,
        ST_RESULT
    } ont_state_t;

    // Bytes after the first zero byte are forced to zero.
    function automatic logic [NAME_W-1:0] ont_canon(input logic [NAME_W-1:0] raw);
        logic              ended;
        logic [7:0]        b;
        logic [NAME_W-1:0] res;
        ended = 1'b0;
        res   = '0;
        for (int i = 0; i < NAME_CHARS; i++) begin
            b = raw[i*8 +: 8];
            if (!ended) begin
                res[i*8 +: 8] = b;
                if (b == 8'h00) begin
                    ended = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> sv/ont_ram.sv
// ----------------------------------------------------------------------------
// ont_ram: name storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ont_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 112
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/ordered_name_table.sv
// ----------------------------------------------------------------------------
// ordered_name_table: ordered list of short names with append, insert,
// search and delete
//
//   channel  dir  tdata fields (low bit first)                      width
//   s_*      in   cmd[1:0] name_low[65:2] name_high[113:66]
//                 position[118:114], bit 119 zero                   120
//   m_*      out  status[1:0] where[5:2] count_after[10:6],
//                 bits 15:11 zero                                   16
//
// Insert and delete move one entry per cycle between the RAM's read and write
// ports. s_tready is high only while idle. Reset empties the table; a result
// not taken holds in the output register and stalls the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_name_table #(
    parameter int DEPTH = ont_pkg::ONT_DEPTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // cmd, name_low, name_high, position (low bit first)
    input  wire logic [119:0] s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // status, where, count_after (low bit first)
    output logic      [15:0]  m_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready
);

    import ont_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > 5) ? CW : 5;   // compare width for position
    localparam int IW = (AW > 4) ? AW : 4;   // index width before masking

    // input fields
    ont_cmd_t          in_cmd;
    logic [NAME_W-1:0] in_name;
    logic [4:0]        in_pos;

    assign in_cmd  = ont_cmd_t'(s_tdata[1:0]);
    assign in_name = {s_tdata[113:66], s_tdata[65:2]};
    assign in_pos  = s_tdata[118:114];

    // sequencer state
    ont_state_t        state_reg,  state_next;
    ont_cmd_t          cmd_reg,    cmd_next;
    logic [NAME_W-1:0] name_reg,   name_next;
    logic [CW-1:0]     cnt_reg,    cnt_next;
    logic [AW-1:0]     at_reg,     at_next;
    logic [AW-1:0]     ptr_reg,    ptr_next;   // next entry to read
    logic [AW-1:0]     end_reg,    end_next;   // last entry to read
    logic [AW-1:0]     tag_reg,    tag_next;   // index tied to read data
    logic              issue_reg,  issue_next;
    logic              pend_reg,   pend_next;
    logic              up_reg,     up_next;    // shift direction
    ont_status_t       status_reg, status_next;
    logic [AW-1:0]     where_reg,  where_next;

    // output register
    logic              m_valid_reg,  m_valid_next;
    ont_status_t       m_status_reg, m_status_next;
    logic [3:0]        m_where_reg,  m_where_next;
    logic [4:0]        m_count_reg,  m_count_next;

    // RAM port
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [NAME_W-1:0] ram_wdata, ram_rdata;

    // helpers
    logic [WW-1:0]     pos_ext, cnt_ext;
    logic [CW-1:0]     cnt_m1;
    logic [AW-1:0]     last_idx;
    logic              full;
    logic [IW-1:0]     where_ext;
    logic [WW-1:0]     count_ext;

    assign pos_ext   = WW'(in_pos);
    assign cnt_ext   = WW'(cnt_reg);
    assign cnt_m1    = cnt_reg - CW'(1);
    assign last_idx  = cnt_m1[AW-1:0];
    assign full      = (cnt_reg == CW'(DEPTH));
    assign where_ext = IW'(where_reg);
    assign count_ext = WW'(cnt_reg);

    ont_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (NAME_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_count_reg, m_where_reg, m_status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            issue_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            issue_reg   <= issue_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        name_reg     <= name_next;
        at_reg       <= at_next;
        ptr_reg      <= ptr_next;
        end_reg      <= end_next;
        tag_reg      <= tag_next;
        up_reg       <= up_next;
        status_reg   <= status_next;
        where_reg    <= where_next;
        m_status_reg <= m_status_next;
        m_where_reg  <= m_where_next;
        m_count_reg  <= m_count_next;
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        name_next     = name_reg;
        cnt_next      = cnt_reg;
        at_next       = at_reg;
        ptr_next      = ptr_reg;
        end_next      = end_reg;
        tag_next      = tag_reg;
        issue_next    = issue_reg;
        pend_next     = 1'b0;
        up_next       = up_reg;
        status_next   = status_reg;
        where_next    = where_reg;
        m_valid_next  = m_valid_reg & ~m_tready;
        m_status_next = m_status_reg;
        m_where_next  = m_where_reg;
        m_count_next  = m_count_reg;
        ram_we        = 1'b0;
        ram_waddr     = at_reg;
        ram_wdata     = name_reg;
        ram_re        = 1'b0;
        ram_raddr     = ptr_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next    = in_cmd;
                    name_next   = ont_canon(in_name);
                    status_next = STAT_OK;
                    where_next  = '0;
                    if (in_cmd == CMD_APPEND || in_cmd == CMD_INSERT) begin
                        if (in_cmd == CMD_INSERT && pos_ext > cnt_ext) begin
                            status_next = STAT_POS;
                            state_next  = ST_RESULT;
                        end else if (full) begin
                            status_next = STAT_FULL;
                            state_next  = ST_RESULT;
                        end else if (in_cmd == CMD_APPEND || pos_ext == cnt_ext) begin
                            at_next    = cnt_reg[AW-1:0];
                            state_next = ST_PLACE;
                        end else begin
                            // move entries pos..count-1 up, highest first
                            at_next    = pos_ext[AW-1:0];
                            up_next    = 1'b1;
                            ptr_next   = last_idx;
                            end_next   = pos_ext[AW-1:0];
                            issue_next = 1'b1;
                            state_next = ST_SHIFT;
                        end
                    end else if (cnt_reg == '0) begin
                        status_next = STAT_MISS;
                        state_next  = ST_RESULT;
                    end else begin
                        ptr_next   = '0;
                        issue_next = 1'b1;
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH: begin
                if (pend_reg && ram_rdata == name_reg) begin
                    where_next = tag_reg;
                    issue_next = 1'b0;
                    if (cmd_reg == CMD_DELETE && tag_reg != last_idx) begin
                        // close the gap: move hit+1..count-1 down
                        up_next    = 1'b0;
                        ptr_next   = tag_reg + AW'(1);
                        end_next   = last_idx;
                        issue_next = 1'b1;
                        state_next = ST_SHIFT;
                    end else begin
                        if (cmd_reg == CMD_DELETE) begin
                            cnt_next = cnt_m1;
                        end
                        state_next = ST_RESULT;
                    end
                end else if (pend_reg && tag_reg == last_idx) begin
                    status_next = STAT_MISS;
                    issue_next  = 1'b0;
                    state_next  = ST_RESULT;
                end else if (issue_reg) begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    tag_next  = ptr_reg;
                    if (ptr_reg == last_idx) begin
                        issue_next = 1'b0;
                    end else begin
                        ptr_next = ptr_reg + AW'(1);
                    end
                end
            end

            ST_SHIFT: begin
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = tag_reg;
                    ram_wdata = ram_rdata;
                end
                if (issue_reg) begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    tag_next  = up_reg ? ptr_reg + AW'(1) : ptr_reg - AW'(1);
                    if (ptr_reg == end_reg) begin
                        issue_next = 1'b0;
                    end else begin
                        ptr_next = up_reg ? ptr_reg - AW'(1) : ptr_reg + AW'(1);
                    end
                end else if (!pend_reg) begin
                    if (up_reg) begin
                        state_next = ST_PLACE;
                    end else begin
                        cnt_next   = cnt_m1;
                        state_next = ST_RESULT;
                    end
                end
            end

            ST_PLACE: begin
                ram_we      = 1'b1;
                cnt_next    = cnt_reg + CW'(1);
                where_next  = at_reg;
                status_next = STAT_OK;
                state_next  = ST_RESULT;
            end

            ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_where_next  = where_ext[3:0];
                    m_count_next  = count_ext[4:0];
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count above table depth");

    a_full_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT && status_reg == STAT_FULL) |-> full)
        else $error("table full reported with free entries");

    a_shift_ports: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT && pend_reg && issue_reg) |-> (tag_reg != ptr_reg))
        else $error("shift reads and writes the same entry");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while a command is in progress");
`endif

endmodule

`default_nettype wire

>>> tb/tb_ordered_name_table.sv
// ----------------------------------------------------------------------------
// tb_ordered_name_table: self-checking bench for the ordered name table
// Drives append, insert, search and delete commands over the input stream,
// predicts each reply from a private copy of the table and compares the
// status, index and count of every reply, under random stalls on both sides.
// ----------------------------------------------------------------------------

// Expected reply of one command.
typedef struct packed {
    ont_pkg::ont_status_t status;
    logic [3:0]           slot;
    logic [4:0]           count_after;
} table_reply_t;

// Shadow copy of the table plus the queue of replies still owed by the block.
class table_scoreboard;
    logic [111:0] names [ont_pkg::ONT_DEPTH];
    int           fill;
    int           fail_cnt;
    table_reply_t replies_due [$];

    function new();
        fill     = 0;
        fail_cnt = 0;
    endfunction

    // A name ends at its first zero byte; everything past it reads as zero.
    function logic [111:0] clip_name(logic [111:0] raw);
        int first_zero;
        first_zero = 14;
        for (int i = 13; i >= 0; i--) begin
            if (raw[i*8 +: 8] == 8'h00) begin
                first_zero = i;
            end
        end
        if (first_zero == 14) begin
            return raw;
        end
        return raw & ((112'd1 << (first_zero * 8)) - 112'd1);
    endfunction

    // Apply one accepted command to the shadow table and queue its reply.
    function void note_command(logic [119:0] item);
        ont_pkg::ont_cmd_t cmd;
        logic [111:0]      nm;
        int                at;
        int                hit;
        table_reply_t      r;
        cmd      = ont_pkg::ont_cmd_t'(item[1:0]);
        nm       = clip_name(item[113:2]);
        r.status = ont_pkg::STAT_OK;
        r.slot   = '0;
        case (cmd)
            ont_pkg::CMD_APPEND, ont_pkg::CMD_INSERT: begin
                at = (cmd == ont_pkg::CMD_APPEND) ? fill : int'(item[118:114]);
                if (at > fill) begin
                    r.status = ont_pkg::STAT_POS;
                end else if (fill >= ont_pkg::ONT_DEPTH) begin
                    r.status = ont_pkg::STAT_FULL;
                end else begin
                    for (int i = fill; i > at; i--) begin
                        names[i] = names[i-1];
                    end
                    names[at] = nm;
                    fill++;
                    r.slot = at[3:0];
                end
            end
            default: begin
                hit = -1;
                for (int i = 0; i < fill; i++) begin
                    if (hit < 0 && names[i] == nm) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    r.status = ont_pkg::STAT_MISS;
                end else begin
                    r.slot = hit[3:0];
                    if (cmd == ont_pkg::CMD_DELETE) begin
                        for (int i = hit; i < fill - 1; i++) begin
                            names[i] = names[i+1];
                        end
                        fill--;
                    end
                end
            end
        endcase
        r.count_after = fill[4:0];
        replies_due.push_back(r);
    endfunction

    // Compare one reply taken from the block with the oldest one owed.
    function void check_reply(logic [15:0] data);
        table_reply_t exp_r;
        table_reply_t got;
        got.status      = ont_pkg::ont_status_t'(data[1:0]);
        got.slot        = data[5:2];
        got.count_after = data[10:6];
        if (replies_due.size() == 0) begin
            $display("%0t: reply with none owed: got %h", $time, data);
            fail_cnt++;
            return;
        end
        exp_r = replies_due.pop_front();
        if (got.status !== exp_r.status) begin
            $display("%0t: status mismatch: expected %0d got %0d",
                     $time, exp_r.status, got.status);
            fail_cnt++;
        end
        if (got.slot !== exp_r.slot) begin
            $display("%0t: index mismatch: expected %0d got %0d",
                     $time, exp_r.slot, got.slot);
            fail_cnt++;
        end
        if (got.count_after !== exp_r.count_after) begin
            $display("%0t: count mismatch: expected %0d got %0d",
                     $time, exp_r.count_after, got.count_after);
            fail_cnt++;
        end
    endfunction

    function int pending();
        return replies_due.size();
    endfunction
endclass

module tb_ordered_name_table;
    import ont_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int POOL_SIZE     = 20;
    localparam int ITEMS_PER_PHASE = 650;

    logic         aclk;
    logic         aresetn;
    logic [119:0] s_tdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [15:0]  m_tdata;
    logic         m_tvalid;
    logic         m_tready;

    table_scoreboard sb;

    // stall knobs, in percent per cycle
    int send_idle;
    int recv_idle;
    // long receiver hold-off, raised by its own process
    logic hold_off;
    int   sent_cnt;
    int   cycle_cnt;

    logic [111:0] name_pool [POOL_SIZE];

    ordered_name_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),   // cmd, name_low, name_high, position (low bit first)
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),   // status, where, count_after (low bit first)
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: any run that outlives the limit is a failure.
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: ready changes on the falling edge; random stalls plus hold-off.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= !hold_off && ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Pressure: once the sender is running flat out, block the result side
    // long enough that the block has a reply parked and holds off input.
    initial begin
        hold_off = 1'b0;
        wait (sent_cnt >= 1400);
        @(posedge aclk);
        hold_off = 1'b1;
        repeat (400) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Replies are sampled on the rising edge, where the handshake completes.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_reply(m_tdata);
        end
    end

    // Layout: bit 119 zero, position, name_high, name_low, cmd.
    function automatic logic [119:0] pack_cmd(ont_cmd_t cmd, logic [111:0] nm,
                                              logic [4:0] pos);
        return {1'b0, pos, nm[111:64], nm[63:0], cmd};
    endfunction

    // Name from a string, first character in the low byte.
    function automatic logic [111:0] str_name(string s);
        logic [111:0] r;
        r = '0;
        for (int i = 0; i < s.len() && i < 14; i++) begin
            r[i*8 +: 8] = s[i];
        end
        return r;
    endfunction

    // Mostly names from the pool (so searches and deletes hit), sometimes
    // with junk after the terminator, now and then fully random bits.
    function automatic logic [111:0] pick_name();
        logic [127:0] w;
        logic [111:0] nm;
        int           len;
        if ($urandom_range(0, 99) < 15) begin
            w = {$urandom, $urandom, $urandom, $urandom};
            return w[111:0];
        end
        nm  = name_pool[$urandom_range(0, POOL_SIZE - 1)];
        len = 14;
        for (int i = 13; i >= 0; i--) begin
            if (nm[i*8 +: 8] == 8'h00) begin
                len = i;
            end
        end
        if ($urandom_range(0, 2) == 0) begin
            for (int j = len + 1; j < 14; j++) begin
                nm[j*8 +: 8] = 8'($urandom_range(0, 255));
            end
        end
        return nm;
    endfunction

    // Offer one item: random idle cycles first, then hold valid until taken.
    task automatic send_item(logic [119:0] item);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 120'({$urandom, $urandom, $urandom, $urandom});
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_command(item);
        sent_cnt++;
        @(negedge aclk);
    endtask

    // Random commands; grow_pct steers the fill level between near empty
    // and full so both the full and the empty corners get traffic.
    task automatic send_random(int n);
        int         grow_pct;
        logic [4:0] pos;
        ont_cmd_t   cmd;
        grow_pct = 50;
        for (int k = 0; k < n; k++) begin
            if (k % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0:       grow_pct = 15;
                    1:       grow_pct = 50;
                    default: grow_pct = 88;
                endcase
            end
            pos = 5'($urandom_range(0, 31));
            if ($urandom_range(0, 99) < grow_pct) begin
                cmd = $urandom_range(0, 1) ? CMD_INSERT : CMD_APPEND;
                if (cmd == CMD_INSERT && $urandom_range(0, 9) != 0) begin
                    pos = 5'($urandom_range(0, sb.fill));
                end
            end else begin
                cmd = $urandom_range(0, 1) ? CMD_DELETE : CMD_SEARCH;
            end
            send_item(pack_cmd(cmd, pick_name(), pos));
        end
    endtask

    initial begin
        int len;
        sb        = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        sent_cnt  = 0;
        send_idle = 29;
        recv_idle = 70;

        // name pool: an empty name, a full-length one, prefixes of the
        // full-length one (exact match, not prefix match), then random
        for (int k = 0; k < POOL_SIZE; k++) begin
            name_pool[k] = '0;
            case (k)
                0:       len = 0;
                1:       len = 14;
                default: len = $urandom_range(1, 14);
            endcase
            for (int i = 0; i < len; i++) begin
                name_pool[k][i*8 +: 8] = 8'($urandom_range(1, 255));
            end
        end
        name_pool[2] = name_pool[1] & {{88{1'b0}}, {24{1'b1}}};
        name_pool[3] = name_pool[1] & {{56{1'b0}}, {56{1'b1}}};
        name_pool[4] = name_pool[1] & {{48{1'b0}}, {64{1'b1}}};
        name_pool[5] = name_pool[1] & {{8{1'b0}}, {104{1'b1}}};

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed: empty table, ordering, terminator handling, full table
        send_item(pack_cmd(CMD_SEARCH, str_name("A"), 5'd0));          // miss, empty
        send_item(pack_cmd(CMD_DELETE, str_name("A"), 5'd0));          // miss, empty
        send_item(pack_cmd(CMD_INSERT, str_name("Q"), 5'd31));         // past count
        send_item(pack_cmd(CMD_APPEND, '0, 5'd0));                     // empty name
        send_item(pack_cmd(CMD_INSERT, '1, 5'd0));                     // all ones, front
        send_item(pack_cmd(CMD_INSERT, str_name("X"), 5'd2));          // insert at count
        send_item(pack_cmd(CMD_SEARCH, ~112'hFF, 5'd0));               // empty + junk
        send_item(pack_cmd(CMD_APPEND, str_name("AB") | (112'hC3 << 72), 5'd0));
        send_item(pack_cmd(CMD_APPEND, str_name("AB"), 5'd0));         // duplicate
        for (int k = 0; k < 11; k++) begin                             // fill to the top
            send_item(pack_cmd(CMD_APPEND, pick_name(), 5'd0));
        end
        send_item(pack_cmd(CMD_APPEND, str_name("Z"), 5'd0));          // full
        send_item(pack_cmd(CMD_INSERT, str_name("Z"), 5'd17));         // past count wins
        send_item(pack_cmd(CMD_INSERT, str_name("Z"), 5'd5));          // full
        send_item(pack_cmd(CMD_DELETE, '1, 5'd0));                     // longest shift
        send_item(pack_cmd(CMD_SEARCH, str_name("AB"), 5'd0));         // lowest dup
        send_item(pack_cmd(CMD_DELETE, str_name("AB"), 5'd0));

        // ---- random, three stall profiles
        send_random(ITEMS_PER_PHASE);
        send_idle = 70;
        recv_idle = 29;
        send_random(ITEMS_PER_PHASE);
        send_idle = 0;
        recv_idle = 0;
        send_random(ITEMS_PER_PHASE);
        s_tvalid <= 1'b0;

        // drain, then allow the worst command time for stray replies
        while (sb.pending() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);

        if (sb.fail_cnt == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/ont_pkg.sv
sv/ont_ram.sv
sv/ordered_name_table.sv
tb/tb_ordered_name_table.sv
